FILE: rtl/bthin_pkg.sv
// Package with shared constants, command codes and the thinning decision function.
`timescale 1ns / 1ps
package bthin_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MEM_SIZE   = MAX_WIDTH * MAX_HEIGHT;
  localparam int MEM_AW     = $clog2(MEM_SIZE);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 16;
  localparam int PIX_W  = 8;
  localparam int DIM_W  = 9;
  localparam int PASS_W = 10;

  localparam logic [PASS_W-1:0] PASS_LIMIT = PASS_W'(1023);
  localparam logic [PIX_W-1:0]  FG_VALUE   = PIX_W'(255);
  localparam logic [PIX_W-1:0]  FG_THRESH  = PIX_W'(128);

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // p[1..8] = p2..p9, clockwise from north
  function automatic logic zs_remove(input logic [8:1] p, input logic odd);
    logic [3:0] a;
    logic [3:0] b;
    logic       m1;
    logic       m2;
    a = '0;
    b = '0;
    for (int k = 1; k <= 8; k++) begin
      b = b + 4'(p[k]);
      if (!p[k] && p[(k == 8) ? 1 : k + 1]) a = a + 4'd1;
    end
    if (odd) begin
      m1 = p[1] & p[3] & p[7];
      m2 = p[1] & p[5] & p[7];
    end else begin
      m1 = p[1] & p[3] & p[5];
      m2 = p[3] & p[5] & p[7];
    end
    return (a == 4'd1) && (b >= 4'd2) && (b <= 4'd6) && !m1 && !m2;
  endfunction

endpackage

FILE: rtl/binary_image_thinning.sv
// Zhang-Suen thinning block: one-bit image RAM, row cache and sweep sequencer.
`timescale 1ns / 1ps
// A load word is answered in the next cycle and a read word after the read state;
// each answers with one result word. In a run every sub-pass is one sweep over the
// image at one pixel per cycle, set by the single read port of the image RAM, plus
// a drain state that empties the window pipeline, and the first iteration adds one
// more sweep that checks whether any foreground remains.
// Input is not taken while a run is in progress or while a result word waits unread.
module binary_image_thinning (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [23:0]               s_axis_tdata,   // pixel_index, pixel_value
  input  logic [bthin_pkg::CMD_W-1:0] s_axis_tuser, // command
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata,   // read_value, pass_count, zero pad
  output logic [bthin_pkg::CMD_W-1:0] m_axis_tuser, // echo_command
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bthin_pkg::DIM_W-1:0] cfg_data_i
);
  import bthin_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  localparam logic [1:0] MODE_EVEN = 2'd0;
  localparam logic [1:0] MODE_ODD  = 2'd1;
  localparam logic [1:0] MODE_SCAN = 2'd2;

  localparam logic [DIM_W-1:0] W_MAX = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] H_MAX = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(3);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_MIN) r = DIM_MIN;
    else if (v > hi) r = hi;
    return r;
  endfunction

  logic [1:0]        state_q, state_d;
  logic [1:0]        mode_q, mode_d;
  logic              first_q, first_d;
  logic              removed_q, removed_d;
  logic              any_q, any_d;
  logic              drain_q, drain_d;
  logic              rd_ok_q, rd_ok_d;
  logic [PASS_W-1:0] pass_q, pass_d;
  logic [DIM_W-1:0]  cfg_w_q, cfg_w_d, cfg_h_q, cfg_h_d;
  logic [DIM_W-1:0]  wc_q, wc_d, hc_q, hc_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [MEM_AW-1:0] addr_q, addr_d;
  logic              out_valid_q, out_valid_d;
  logic [CMD_W-1:0]  out_cmd_q, out_cmd_d;
  logic [PIX_W-1:0]  out_rv_q, out_rv_d;
  logic [PASS_W-1:0] out_pc_q, out_pc_d;

  logic              v1_q, v2_q;
  logic [ROW_W-1:0]  row1_q, row2_q;
  logic [COL_W-1:0]  col1_q, col2_q;
  logic [MEM_AW-1:0] addr1_q, wa2_q;
  logic [2:0]        win_l_q, win_m_q, win_r_q;
  logic              img_rd_q;
  logic [2:0]        cache_rd_q;

  logic              img_mem [MEM_SIZE];
  logic [2:0]        cache_mem [MAX_WIDTH];

  logic              accept;
  logic [IDX_W-1:0]  in_idx;
  logic [PIX_W-1:0]  in_val;
  logic              idx_ok;
  logic [COL_W-1:0]  wlast;
  logic [ROW_W-1:0]  hlast;
  logic              last_px;
  logic [2:0]        new_word;
  logic [8:1]        nbr;
  logic              del;
  logic [PASS_W-1:0] pass_inc;
  logic              img_we;
  logic              img_wd;
  logic [MEM_AW-1:0] img_wa;
  logic [MEM_AW-1:0] img_ra;

  assign in_idx   = s_axis_tdata[IDX_W-1:0];
  assign in_val   = s_axis_tdata[IDX_W+PIX_W-1:IDX_W];
  assign idx_ok   = 32'(in_idx) < MEM_SIZE;
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept   = s_axis_tvalid && s_axis_tready;

  assign wlast    = COL_W'(wc_q - DIM_W'(1));
  assign hlast    = ROW_W'(hc_q - DIM_W'(1));
  assign last_px  = (row_q == hlast) && (col_q == wlast);
  // word bits: [2] row above, [1] center row, [0] row below
  assign new_word = {cache_rd_q[1:0], img_rd_q};
  assign nbr      = {win_l_q[2], win_l_q[1], win_l_q[0], win_m_q[0],
                     win_r_q[0], win_r_q[1], win_r_q[2], win_m_q[2]};
  assign del      = v2_q && (mode_q != MODE_SCAN) && (row2_q >= ROW_W'(2)) &&
                    (col2_q >= COL_W'(2)) && win_m_q[1] &&
                    zs_remove(nbr, mode_q == MODE_ODD);
  assign pass_inc = (pass_q == PASS_LIMIT) ? pass_q : pass_q + PASS_W'(1);

  assign img_we = del || (accept && (s_axis_tuser == CMD_LOAD) && idx_ok);
  assign img_wd = !del && (in_val >= FG_THRESH);
  assign img_wa = del ? wa2_q : in_idx[MEM_AW-1:0];
  assign img_ra = (state_q == ST_SWEEP) ? addr_q : in_idx[MEM_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (img_we) img_mem[img_wa] <= img_wd;
    img_rd_q <= img_mem[img_ra];
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) cache_mem[col1_q] <= new_word;
    cache_rd_q <= cache_mem[col_q];
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    first_d     = first_q;
    removed_d   = removed_q;
    any_d       = any_q;
    drain_d     = drain_q;
    rd_ok_d     = rd_ok_q;
    pass_d      = pass_q;
    cfg_w_d     = cfg_w_q;
    cfg_h_d     = cfg_h_q;
    wc_d        = wc_q;
    hc_d        = hc_q;
    row_d       = row_q;
    col_d       = col_q;
    addr_d      = addr_q;
    out_valid_d = out_valid_q;
    out_cmd_d   = out_cmd_q;
    out_rv_d    = out_rv_q;
    out_pc_d    = out_pc_q;

    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    if (cfg_we_i) begin
      if (cfg_idx_i == REG_WIDTH) cfg_w_d = cfg_data_i;
      else cfg_h_d = cfg_data_i;
    end
    if (del) removed_d = 1'b1;
    if (v1_q && (mode_q == MODE_SCAN) && img_rd_q) any_d = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            CMD_READ: begin
              rd_ok_d = idx_ok;
              state_d = ST_READ;
            end
            CMD_RUN: begin
              wc_d      = clamp_dim(cfg_w_q, W_MAX);
              hc_d      = clamp_dim(cfg_h_q, H_MAX);
              pass_d    = '0;
              first_d   = 1'b1;
              removed_d = 1'b0;
              mode_d    = MODE_EVEN;
              row_d     = '0;
              col_d     = '0;
              addr_d    = '0;
              state_d   = ST_SWEEP;
            end
            default: begin
              out_valid_d = 1'b1;
              out_cmd_d   = s_axis_tuser;
              out_rv_d    = '0;
              out_pc_d    = '0;
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        out_cmd_d   = CMD_READ;
        out_rv_d    = (rd_ok_q && img_rd_q) ? FG_VALUE : '0;
        out_pc_d    = '0;
        state_d     = ST_IDLE;
      end
      ST_SWEEP: begin
        addr_d = addr_q + MEM_AW'(1);
        if (col_q == wlast) begin
          col_d = '0;
          row_d = row_q + ROW_W'(1);
        end else begin
          col_d = col_q + COL_W'(1);
        end
        if (last_px) begin
          drain_d = 1'b0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!drain_q) begin
          drain_d = 1'b1;
        end else begin
          row_d  = '0;
          col_d  = '0;
          addr_d = '0;
          case (mode_q)
            MODE_EVEN: begin
              mode_d  = MODE_ODD;
              state_d = ST_SWEEP;
            end
            MODE_ODD: begin
              pass_d = pass_inc;
              if (first_q) begin
                first_d = 1'b0;
                any_d   = 1'b0;
                mode_d  = MODE_SCAN;
                state_d = ST_SWEEP;
              end else if (removed_q || del) begin
                removed_d = 1'b0;
                mode_d    = MODE_EVEN;
                state_d   = ST_SWEEP;
              end else begin
                out_valid_d = 1'b1;
                out_cmd_d   = CMD_RUN;
                out_rv_d    = '0;
                out_pc_d    = pass_inc;
                state_d     = ST_IDLE;
              end
            end
            MODE_SCAN: begin
              if (any_q) begin
                removed_d = 1'b0;
                mode_d    = MODE_EVEN;
                state_d   = ST_SWEEP;
              end else begin
                out_valid_d = 1'b1;
                out_cmd_d   = CMD_RUN;
                out_rv_d    = '0;
                out_pc_d    = pass_q;
                state_d     = ST_IDLE;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_EVEN;
      first_q     <= 1'b0;
      removed_q   <= 1'b0;
      any_q       <= 1'b0;
      drain_q     <= 1'b0;
      rd_ok_q     <= 1'b0;
      pass_q      <= '0;
      cfg_w_q     <= W_MAX;
      cfg_h_q     <= H_MAX;
      wc_q        <= W_MAX;
      hc_q        <= H_MAX;
      row_q       <= '0;
      col_q       <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      first_q     <= first_d;
      removed_q   <= removed_d;
      any_q       <= any_d;
      drain_q     <= drain_d;
      rd_ok_q     <= rd_ok_d;
      pass_q      <= pass_d;
      cfg_w_q     <= cfg_w_d;
      cfg_h_q     <= cfg_h_d;
      wc_q        <= wc_d;
      hc_q        <= hc_d;
      row_q       <= row_d;
      col_q       <= col_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
      v1_q        <= (state_q == ST_SWEEP);
      v2_q        <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cmd_q <= out_cmd_d;
    out_rv_q  <= out_rv_d;
    out_pc_q  <= out_pc_d;
    row1_q    <= row_q;
    col1_q    <= col_q;
    addr1_q   <= addr_q;
    row2_q    <= row1_q;
    col2_q    <= col1_q;
    // center of the window is one row up and one column left of the newest pixel
    wa2_q     <= MEM_AW'({1'b0, addr1_q} - (MEM_AW + 1)'(wc_q) - (MEM_AW + 1)'(1));
    if (v1_q) begin
      win_l_q <= win_m_q;
      win_m_q <= win_r_q;
      win_r_q <= new_word;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_cmd_q;
  assign m_axis_tdata  = {6'b0, out_pc_q, out_rv_q};

endmodule

FILE: rtl/bthin_checker.sv
// Port-level checker for the thinning block, bound to the top level.
`timescale 1ns / 1ps
module bthin_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [bthin_pkg::CMD_W-1:0] s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [23:0]                 m_axis_tdata,
  input logic [bthin_pkg::CMD_W-1:0] m_axis_tuser
);
  import bthin_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped before taken");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result word is pending");

  a_load_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_LOAD) |=>
      m_axis_tvalid && (m_axis_tuser == CMD_LOAD) && (m_axis_tdata == 24'd0))
    else $error("load word not answered in the next cycle");

  a_read_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'd0) || (m_axis_tdata[7:0] == FG_VALUE))
    else $error("read value neither 0 nor 255");

  a_pass_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != CMD_RUN) |-> (m_axis_tdata[17:8] == 10'd0))
    else $error("pass count set on a non-run result");

endmodule

bind binary_image_thinning bthin_checker u_bthin_checker (.*);
